// ----- hw/rtl/rau_pkg.sv -----
// Package for the rational arithmetic unit: status, mode and state codes,
// shared-adder request/response types and sizing constants.
// No dependencies.
package rau_pkg;

  localparam int MAG_W       = 64;  // magnitude datapath width
  localparam int IN_W        = 32;  // width of one operand field
  localparam int CNT_W       = 6;   // step counter, up to MAG_W-1
  localparam int OPERAND_W_D = 32;  // default operand width
  localparam int TDATA_W     = 136; // both channels, padded to bytes

  localparam logic [2:0] MODE_ADD  = 3'd0;
  localparam logic [2:0] MODE_SUB  = 3'd1;
  localparam logic [2:0] MODE_MUL  = 3'd2;
  localparam logic [2:0] MODE_DIV  = 3'd3;
  localparam logic [2:0] MODE_SIMP = 3'd4;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_DIVZERO  = 2'd1,
    STAT_ZERODEN  = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_COMB, S_COMB2, S_PREP, S_GEVEN, S_GXODD, S_GCD,
    S_GSHIFT, S_DIV, S_CHECK, S_DONE
  } state_e;

  typedef struct packed {
    logic             sub;
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [MAG_W-1:0] res;
    logic             borrow;  // carry out on add, a < b on subtract
  } alu_rsp_t;

endpackage

// ----- hw/rtl/rau_alu.sv -----
// Shared 64-bit add/subtract unit of the rational arithmetic unit.
// Depends on rau_pkg.
module rau_alu (
  input  rau_pkg::alu_req_t req_i,
  output rau_pkg::alu_rsp_t rsp_o
);
  import rau_pkg::*;

  logic [MAG_W:0] sum;

  always_comb begin
    if (req_i.sub) begin
      sum = {1'b0, req_i.a} - {1'b0, req_i.b};
    end else begin
      sum = {1'b0, req_i.a} + {1'b0, req_i.b};
    end
    rsp_o.res    = sum[MAG_W-1:0];
    rsp_o.borrow = sum[MAG_W];
  end

endmodule

// ----- hw/rtl/rational_arith_unit.sv -----
// Top level of the rational arithmetic unit: sequencer, registers and
// output stage around one shared 64-bit adder. Depends on rau_pkg, rau_alu.
//
// Channel  Dir  Bits (low to high)
// s_axis   in   mode[2:0] a_num[34:3] a_den[66:35] b_num[98:67] b_den[130:99]
// m_axis   out  res_num[63:0] res_den[126:64] status[128:127]
//
// An error item goes from idle straight to the done state and on to the output
// register, and a zero result skips the gcd and the divisions after the products.
// Any other item runs the shift-add products (three for add or subtract, two
// for multiply or divide, none for simplify), the combine step for add or
// subtract, the shifts, swaps and subtracts of the binary gcd and the two long
// divisions by the gcd, all on the single shared adder.
// s_axis_tready is high only while the sequencer is idle. A finished result
// sits in the output register; the next item is taken while it waits, and
// the sequencer holds at its end until the output register is free.
// Reset (rst_ni low, asynchronous) returns to idle and drops the output.
module rational_arith_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_W_D
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // mode, a_num, a_den, b_num, b_den, zero pad
  input  logic [rau_pkg::TDATA_W-1:0] s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // res_num, res_den, status, zero pad
  output logic [rau_pkg::TDATA_W-1:0] m_axis_tdata
);
  import rau_pkg::*;

  localparam int W = OPERAND_WIDTH;

  state_e state_q, state_d;

  // input unpacking
  logic [2:0]    in_mode;
  logic [IN_W-1:0] in_an, in_ad, in_bn, in_bd;
  assign in_mode = s_axis_tdata[2:0];
  assign in_an   = s_axis_tdata[34:3];
  assign in_ad   = s_axis_tdata[66:35];
  assign in_bn   = s_axis_tdata[98:67];
  assign in_bd   = s_axis_tdata[130:99];

  function automatic logic [W-1:0] mag_of(input logic [IN_W-1:0] raw);
    logic [W-1:0] v;
    v = raw[W-1:0];
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  logic [W-1:0] m_an, m_ad, m_bn, m_bd;
  logic         g_an, g_ad, g_bn, g_bd;
  assign m_an = mag_of(in_an);
  assign m_ad = mag_of(in_ad);
  assign m_bn = mag_of(in_bn);
  assign m_bd = mag_of(in_bd);
  assign g_an = in_an[W-1];
  assign g_ad = in_ad[W-1];
  assign g_bn = in_bn[W-1];
  assign g_bd = in_bd[W-1];

  logic accept;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // working registers
  logic [2:0]       mode_q, mode_d;
  logic [W-1:0]     ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  logic [1:0]       k_q, k_d;          // product index
  logic [CNT_W-1:0] cnt_q, cnt_d;      // multiply / divide step
  logic [CNT_W-1:0] sh_q, sh_d;        // common power of two in the gcd
  logic [MAG_W-1:0] acc_q, acc_d, mcand_q, mcand_d;
  logic [W-1:0]     mplier_q, mplier_d;
  logic [MAG_W-1:0] p0_q, p0_d, p1_q, p1_d;
  logic [MAG_W-1:0] num_q, num_d, den_q, den_d;
  logic [MAG_W-1:0] x_q, x_d, y_q, y_d, g_q, g_d;
  logic [MAG_W-1:0] dq_q, dq_d, rem_q, rem_d, nm_q, nm_d, dm_q, dm_d;
  logic             phase_q, phase_d;
  logic             nsg_q, nsg_d, s2_q, s2_d, dsg_q, dsg_d;
  logic [MAG_W-1:0] rnum_q, rnum_d;
  logic [MAG_W-2:0] rden_q, rden_d;
  status_e          rst_q, rst_d;
  logic             ov_q, ov_d;        // output valid
  logic [MAG_W-1:0] onum_q, onum_d;
  logic [MAG_W-2:0] oden_q, oden_d;
  status_e          ost_q, ost_d;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  rau_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  logic addsub;
  logic last_prod;
  logic zero_den_in;
  logic mul_done;
  logic div_done;
  logic [MAG_W-1:0] div_t;
  logic neg_res;
  assign addsub    = (mode_q == MODE_ADD) || (mode_q == MODE_SUB);
  assign last_prod = addsub ? (k_q == 2'd2) : (k_q == 2'd1);
  assign zero_den_in = (m_ad == '0) || (!in_mode[2] && (m_bd == '0));
  assign mul_done  = (cnt_q == CNT_W'(W - 1));
  assign div_done  = (cnt_q == CNT_W'(MAG_W - 1));
  assign div_t     = {rem_q[MAG_W-2:0], dq_q[MAG_W-1]};
  assign neg_res   = (nsg_q != dsg_q) && (nm_q != '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (zero_den_in || (in_mode == MODE_DIV && m_bn == '0)) begin
            state_d = S_DONE;
          end else if (in_mode[2]) begin
            state_d = S_PREP;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (mul_done && last_prod) begin
          state_d = addsub ? S_COMB : S_PREP;
        end
      end
      S_COMB: begin
        if (nsg_q != s2_q && alu_rsp.borrow) begin
          state_d = S_COMB2;
        end else begin
          state_d = S_PREP;
        end
      end
      S_COMB2:  state_d = S_PREP;
      S_PREP:   state_d = (num_q == '0) ? S_CHECK : S_GEVEN;
      S_GEVEN:  if (x_q[0] || y_q[0]) state_d = S_GXODD;
      S_GXODD:  if (x_q[0]) state_d = S_GCD;
      S_GCD:    if (y_q == '0) state_d = S_GSHIFT;
      S_GSHIFT: state_d = S_DIV;
      S_DIV:    if (div_done && phase_q) state_d = S_CHECK;
      S_CHECK:  state_d = S_DONE;
      S_DONE:   if (!ov_q || m_axis_tready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mode_d = mode_q; ad_d = ad_q; bn_d = bn_q; bd_d = bd_q;
    k_d = k_q; cnt_d = cnt_q; sh_d = sh_q;
    acc_d = acc_q; mcand_d = mcand_q; mplier_d = mplier_q;
    p0_d = p0_q; p1_d = p1_q; num_d = num_q; den_d = den_q;
    x_d = x_q; y_d = y_q; g_d = g_q;
    dq_d = dq_q; rem_d = rem_q; nm_d = nm_q; dm_d = dm_q; phase_d = phase_q;
    nsg_d = nsg_q; s2_d = s2_q; dsg_d = dsg_q;
    rnum_d = rnum_q; rden_d = rden_q; rst_d = rst_q;
    ov_d = ov_q; onum_d = onum_q; oden_d = oden_q; ost_d = ost_q;
    alu_req = '{sub: 1'b0, a: acc_q, b: mcand_q};

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d = in_mode;
          ad_d = m_ad; bn_d = m_bn; bd_d = m_bd;
          k_d = '0; cnt_d = '0; acc_d = '0;
          // first product: a_num times b_num (multiply) or b_den
          mcand_d  = MAG_W'(m_an);
          mplier_d = (in_mode == MODE_MUL) ? m_bn : m_bd;
          num_d = MAG_W'(m_an);
          den_d = MAG_W'(m_ad);
          s2_d  = g_bn ^ g_ad ^ (in_mode == MODE_SUB);
          if (in_mode[2]) begin
            nsg_d = g_an; dsg_d = g_ad;
          end else if (in_mode == MODE_MUL) begin
            nsg_d = g_an ^ g_bn; dsg_d = g_ad ^ g_bd;
          end else if (in_mode == MODE_DIV) begin
            nsg_d = g_an ^ g_bd; dsg_d = g_ad ^ g_bn;
          end else begin
            nsg_d = g_an ^ g_bd; dsg_d = g_ad ^ g_bd;
          end
          rnum_d = '0; rden_d = '0;
          if (zero_den_in) begin
            rst_d = STAT_ZERODEN;
          end else if (in_mode == MODE_DIV && m_bn == '0) begin
            rst_d = STAT_DIVZERO;
          end else begin
            rst_d = STAT_OK;
          end
        end
      end
      S_MUL: begin
        alu_req = '{sub: 1'b0, a: acc_q, b: mcand_q};
        acc_d    = mplier_q[0] ? alu_rsp.res : acc_q;
        mcand_d  = {mcand_q[MAG_W-2:0], 1'b0};
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + 1'b1;
        if (mul_done) begin
          cnt_d = '0;
          k_d   = k_q + 1'b1;
          // store the finished product before clearing the accumulator
          if (k_q == 2'd0) begin
            p0_d = acc_d;
          end else if (k_q == 2'd1) begin
            p1_d = acc_d;
          end
          if (last_prod) begin
            if (addsub) begin
              den_d = acc_d;
            end else begin
              num_d = p0_q;
              den_d = acc_d;
            end
          end else if (k_q == 2'd0) begin
            // second product
            mcand_d  = MAG_W'(ad_q);
            if (addsub) begin
              mplier_d = bn_q;
            end else if (mode_q == MODE_MUL) begin
              mplier_d = bd_q;
            end else begin
              mplier_d = bn_q;
            end
          end else begin
            mcand_d  = MAG_W'(ad_q);
            mplier_d = bd_q;
          end
          acc_d = '0;
        end
      end
      S_COMB: begin
        alu_req = '{sub: (nsg_q != s2_q), a: p0_q, b: p1_q};
        num_d = alu_rsp.res;
        if (nsg_q != s2_q && alu_rsp.borrow) begin
          nsg_d = s2_q;
        end
      end
      S_COMB2: begin
        alu_req = '{sub: 1'b1, a: p1_q, b: p0_q};
        num_d = alu_rsp.res;
      end
      S_PREP: begin
        x_d = num_q; y_d = den_q; sh_d = '0;
        nm_d = '0; dm_d = MAG_W'(1);
      end
      S_GEVEN: begin
        if (!(x_q[0] || y_q[0])) begin
          x_d = x_q >> 1; y_d = y_q >> 1; sh_d = sh_q + 1'b1;
        end
      end
      S_GXODD: begin
        if (!x_q[0]) x_d = x_q >> 1;
      end
      S_GCD: begin
        alu_req = '{sub: 1'b1, a: y_q, b: x_q};
        if (y_q != '0) begin
          if (!y_q[0]) begin
            y_d = y_q >> 1;
          end else if (alu_rsp.borrow) begin
            x_d = y_q; y_d = x_q;
          end else begin
            y_d = alu_rsp.res;
          end
        end
      end
      S_GSHIFT: begin
        g_d = x_q << sh_q;
        dq_d = num_q; rem_d = '0; cnt_d = '0; phase_d = 1'b0;
      end
      S_DIV: begin
        alu_req = '{sub: 1'b1, a: div_t, b: g_q};
        rem_d = alu_rsp.borrow ? div_t : alu_rsp.res;
        dq_d  = {dq_q[MAG_W-2:0], !alu_rsp.borrow};
        cnt_d = cnt_q + 1'b1;
        if (div_done) begin
          if (!phase_q) begin
            nm_d = dq_d;
            dq_d = den_q; rem_d = '0; phase_d = 1'b1;
          end else begin
            dm_d = dq_d;
          end
        end
      end
      S_CHECK: begin
        if (dm_q[MAG_W-1] ||
            (nm_q[MAG_W-1] && !(neg_res && nm_q[MAG_W-2:0] == '0))) begin
          rst_d = STAT_OVERFLOW; rnum_d = '0; rden_d = '0;
        end else begin
          rnum_d = neg_res ? (~nm_q + 1'b1) : nm_q;
          rden_d = dm_q[MAG_W-2:0];
        end
      end
      S_DONE: begin
        // hand over to the output register once it is free
        if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1; onum_d = rnum_q; oden_d = rden_q; ost_d = rst_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d; ad_q <= ad_d; bn_q <= bn_d; bd_q <= bd_d;
    k_q <= k_d; cnt_q <= cnt_d; sh_q <= sh_d;
    acc_q <= acc_d; mcand_q <= mcand_d; mplier_q <= mplier_d;
    p0_q <= p0_d; p1_q <= p1_d; num_q <= num_d; den_q <= den_d;
    x_q <= x_d; y_q <= y_d; g_q <= g_d;
    dq_q <= dq_d; rem_q <= rem_d; nm_q <= nm_d; dm_q <= dm_d;
    phase_q <= phase_d;
    nsg_q <= nsg_d; s2_q <= s2_d; dsg_q <= dsg_d;
    rnum_q <= rnum_d; rden_q <= rden_d; rst_q <= rst_d;
    onum_q <= onum_d; oden_q <= oden_d; ost_q <= ost_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {7'd0, ost_q, oden_q, onum_q};

  // the odd gcd candidate stays odd through the subtract loop
  a_gcd_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GCD) |-> x_q[0])
    else $error("gcd candidate lost oddness");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ost_q != STAT_OK) |-> (onum_q == '0 && oden_q == '0))
    else $error("error result carries nonzero payload");

  a_ok_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ost_q == STAT_OK) |-> (oden_q != '0))
    else $error("ok result with zero denominator");

endmodule
